// ===== hw/rtl/varint_strip_index_decoder_unit_macros.svh =====
// Assertion macros for the varint strip index decoder.
// Included by the top level; needs nothing else.
`ifndef VARINT_STRIP_INDEX_DECODER_UNIT_MACROS_SVH
`define VARINT_STRIP_INDEX_DECODER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define VSID_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vsid assertion failed");

// Next-cycle implication.
`define VSID_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vsid assertion failed");

`else

`define VSID_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define VSID_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/vsid_pkg.sv =====
// Shared types and constants of the varint strip index decoder.
// No dependencies.
package vsid_pkg;

   localparam int PAYLOAD_BITS     = 7;
   localparam int CONT_BIT         = 7;
   localparam int MAX_VARINT_BYTES = 5;
   localparam int ACC_BITS         = 32;
   localparam int WIDE_BITS        = 35;   // 5 bytes of 7 payload bits
   localparam int LEN_BITS         = 31;
   localparam int BCNT_BITS        = 3;
   localparam int SHIFT_BITS       = 6;

   typedef enum logic [1:0] {
      PH_LEN  = 2'd0,
      PH_IDX  = 2'd1,
      PH_DONE = 2'd2
   } phase_type;

   // One completed varint, already classified by the front end.
   typedef struct packed {
      logic [ACC_BITS-1:0] value;    // low 32 payload bits
      logic                big;      // value is 2^31 or more
      logic                is_zero;  // whole varint is zero
      logic                last;     // completed by the final byte
   } token_type;

   // Queue state seen by the front and back.
   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

endpackage

// ===== hw/rtl/varint_strip_index_decoder_unit.sv =====
// Top level of the varint strip index decoder: front end, token queue, back end.
// Depends on vsid_pkg, vsid_front, vsid_queue, vsid_back and the macros header.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------
//   req     | in        | req_valid/req_ready  | byte_in[7:0], final_byte
//   rsp     | out       | rsp_valid/rsp_ready  | index_valid, index_value, strip_end,
//           |           |                      | status
//
// One byte per cycle while the token queue has room; a result leaves the output register
// once the byte that completes its varint has passed the queue entry, then the result register.
// The front end accumulates each byte into its varint; the back end does one subtract and
// compare per token.
// Reset is synchronous; there is no clearing pass.
// An rsp stall fills the token queue; req_ready falls only once the queue is full.
`include "varint_strip_index_decoder_unit_macros.svh"

module varint_strip_index_decoder_unit import vsid_pkg::*; #(
   parameter int INDEX_BITS  = 16,  // 8 to 32
   parameter int QUEUE_DEPTH = 2    // 2 to 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_byte_in,
   input  logic                  req_final_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_index_valid,
   output logic [INDEX_BITS-1:0] rsp_index_value,
   output logic                  rsp_strip_end,
   output logic                  rsp_status
);

   queue_status_type q_status;
   token_type        push_tok;
   token_type        head_tok;
   logic             tok_push;
   logic             tok_pop;

   // Varint assembly; one token per completed varint.
   vsid_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_byte_in    (req_byte_in),
      .req_final_byte (req_final_byte),
      .q_status       (q_status),
      .tok_push       (tok_push),
      .tok_data       (push_tok)
   );

   // Decouples byte intake from result delivery.
   vsid_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (tok_push),
      .push_data (push_tok),
      .pop       (tok_pop),
      .head_data (head_tok),
      .status    (q_status)
   );

   // Strip length, index arithmetic and the result register.
   vsid_back #(
      .INDEX_BITS (INDEX_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .tok_data        (head_tok),
      .tok_pop         (tok_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_index_valid (rsp_index_valid),
      .rsp_index_value (rsp_index_value),
      .rsp_strip_end   (rsp_strip_end),
      .rsp_status      (rsp_status)
   );

   // No token written into a full queue.
   `VSID_ASSERT_IMPLIES(a_no_push_when_full, clock, reset, tok_push, !q_status.full)
   // A result without an index always closes the strip.
   `VSID_ASSERT_IMPLIES(a_noidx_ends, clock, reset, rsp_valid && !rsp_index_valid, rsp_strip_end)
   // A result without an index carries a zero value.
   `VSID_ASSERT_IMPLIES(a_noidx_zero, clock, reset, rsp_valid && !rsp_index_valid, rsp_index_value == '0)
   // Truncation is only reported on the closing result.
   `VSID_ASSERT_IMPLIES(a_status_ends, clock, reset, rsp_valid && rsp_status, rsp_strip_end)

endmodule

// ===== hw/rtl/vsid_front.sv =====
// Front end: takes bytes, assembles base-128 varints, emits a token per varint.
// Depends on vsid_pkg.
module vsid_front import vsid_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_byte_in,
   input  logic             req_final_byte,
   input  queue_status_type q_status,
   output logic             tok_push,
   output token_type        tok_data
);

   logic [ACC_BITS-1:0]  acc_ff, acc_in;
   logic                 pnz_ff, pnz_in;
   logic [BCNT_BITS-1:0] bcnt_ff, bcnt_in;

   logic [WIDE_BITS-1:0]  wide;
   logic [SHIFT_BITS-1:0] shift_amt;
   logic [ACC_BITS-1:0]   acc_new;
   logic                  pnz_new;
   logic                  take;
   logic                  done_varint;
   logic                  accept;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      take        = (bcnt_ff < BCNT_BITS'(MAX_VARINT_BYTES));
      shift_amt   = SHIFT_BITS'(bcnt_ff) * SHIFT_BITS'(PAYLOAD_BITS);
      wide        = WIDE_BITS'(req_byte_in[PAYLOAD_BITS-1:0]) << shift_amt;
      acc_new     = acc_ff;
      pnz_new     = pnz_ff;
      if (take) begin
         acc_new = acc_ff | wide[ACC_BITS-1:0];
         pnz_new = pnz_ff | (|wide[WIDE_BITS-1:ACC_BITS]);
      end
      done_varint = !req_byte_in[CONT_BIT] || req_final_byte;

      tok_push         = accept && done_varint;
      tok_data.value   = acc_new;
      tok_data.big     = pnz_new || acc_new[ACC_BITS-1];
      tok_data.is_zero = (acc_new == '0) && !pnz_new;
      tok_data.last    = req_final_byte;

      acc_in  = acc_ff;
      pnz_in  = pnz_ff;
      bcnt_in = bcnt_ff;
      if (accept) begin
         if (done_varint) begin
            acc_in  = '0;
            pnz_in  = 1'b0;
            bcnt_in = '0;
         end else begin
            acc_in  = acc_new;
            pnz_in  = pnz_new;
            bcnt_in = take ? bcnt_ff + 1'b1 : bcnt_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         pnz_ff  <= 1'b0;
         bcnt_ff <= '0;
      end else begin
         acc_ff  <= acc_in;
         pnz_ff  <= pnz_in;
         bcnt_ff <= bcnt_in;
      end
   end

endmodule

// ===== hw/rtl/vsid_queue.sv =====
// Token queue between front and back ends; DEPTH entries of flip-flops.
// Depends on vsid_pkg.
module vsid_queue import vsid_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  token_type        push_data,
   input  logic             pop,
   output token_type        head_data,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   token_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign head_data        = mem_ff[rd_ptr_ff];
   assign status.full      = (count_ff == CNT_W'(DEPTH));
   assign status.not_empty = (count_ff != '0);

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/vsid_back.sv =====
// Back end: strip length / index state machine and the result register.
// Depends on vsid_pkg.
module vsid_back import vsid_pkg::*; #(
   parameter int INDEX_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  queue_status_type      q_status,
   input  token_type             tok_data,
   output logic                  tok_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_index_valid,
   output logic [INDEX_BITS-1:0] rsp_index_value,
   output logic                  rsp_strip_end,
   output logic                  rsp_status
);

   phase_type             phase_ff, phase_in;
   logic [LEN_BITS-1:0]   remain_ff, remain_in;
   logic [INDEX_BITS-1:0] zcnt_ff, zcnt_in;

   logic                  out_valid_ff, out_valid_in;
   logic                  out_ivalid_ff, out_ivalid_in;
   logic [INDEX_BITS-1:0] out_value_ff, out_value_in;
   logic                  out_end_ff, out_end_in;
   logic                  out_status_ff, out_status_in;

   logic                  produce;
   logic                  owed;
   logic [INDEX_BITS-1:0] idx_value;

   assign tok_pop   = q_status.not_empty && (!out_valid_ff || rsp_ready);
   assign idx_value = zcnt_ff - tok_data.value[INDEX_BITS-1:0];
   assign owed      = (remain_ff != LEN_BITS'(1));

   always_comb begin
      phase_in      = phase_ff;
      remain_in     = remain_ff;
      zcnt_in       = zcnt_ff;
      produce       = 1'b0;
      out_ivalid_in = out_ivalid_ff;
      out_value_in  = out_value_ff;
      out_end_in    = out_end_ff;
      out_status_in = out_status_ff;

      if (tok_pop) begin
         unique case (phase_ff)
            PH_LEN: begin
               remain_in = tok_data.big ? '0 : tok_data.value[LEN_BITS-1:0];
               if (tok_data.big || tok_data.value[LEN_BITS-1:0] == '0) begin
                  // empty strip, or a length of 2^31 or more
                  produce       = 1'b1;
                  out_ivalid_in = 1'b0;
                  out_value_in  = '0;
                  out_end_in    = 1'b1;
                  out_status_in = 1'b0;
                  phase_in      = PH_DONE;
               end else begin
                  phase_in = PH_IDX;
                  if (tok_data.last) begin
                     // string ended right after the length
                     produce       = 1'b1;
                     out_ivalid_in = 1'b0;
                     out_value_in  = '0;
                     out_end_in    = 1'b1;
                     out_status_in = 1'b1;
                  end
               end
            end
            PH_IDX: begin
               if (tok_data.is_zero) begin
                  zcnt_in = zcnt_ff + 1'b1;
               end
               remain_in     = remain_ff - 1'b1;
               produce       = 1'b1;
               out_ivalid_in = 1'b1;
               out_value_in  = idx_value;
               out_end_in    = !owed || tok_data.last;
               out_status_in = owed && tok_data.last;
               if (!owed) begin
                  phase_in = PH_DONE;
               end
            end
            default: begin
               // strip done: tokens dropped until the final byte
            end
         endcase
         if (tok_data.last) begin
            phase_in  = PH_LEN;
            remain_in = '0;
            zcnt_in   = '0;
         end
      end

      if (produce) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LEN;
         remain_ff    <= '0;
         zcnt_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         remain_ff    <= remain_in;
         zcnt_ff      <= zcnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ivalid_ff <= out_ivalid_in;
      out_value_ff  <= out_value_in;
      out_end_ff    <= out_end_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_index_valid = out_ivalid_ff;
   assign rsp_index_value = out_value_ff;
   assign rsp_strip_end   = out_end_ff;
   assign rsp_status      = out_status_ff;

endmodule
